### rtl/rfsp_pkg.sv
package rfsp_pkg;

  localparam int unsigned WIN_W = 16;

  typedef enum logic [1:0] {
    SEG_BEFORE = 2'd0,
    SEG_RISE   = 2'd1,
    SEG_FALL   = 2'd2,
    SEG_AFTER  = 2'd3
  } seg_t;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_RISE  = 2'd1,
    REG_FALL  = 2'd2,
    REG_PEAK  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    seg_t             seg;
    logic [WIN_W-1:0] elapsed;
    logic [WIN_W-1:0] len;
  } item_t;

endpackage

### rtl/rfsp_front.sv
module rfsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [31:0]         time_now,
  input  logic [31:0]         start_tick,
  input  logic [15:0]         rise_ticks,
  input  logic [15:0]         fall_ticks,
  output logic                push,
  output rfsp_pkg::item_t     item,
  input  logic                full
);
  import rfsp_pkg::*;

  logic        s1_valid;
  logic        s1_before;
  logic [31:0] s1_diff;
  logic [32:0] diff_next;
  logic [16:0] total;
  logic [31:0] past_rise;

  assign diff_next = {1'b0, time_now} - {1'b0, start_tick};
  assign req_ready = !s1_valid || !full;
  assign push      = s1_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_before <= diff_next[32];
      s1_diff   <= diff_next[31:0];
    end
  end

  assign total     = {1'b0, rise_ticks} + {1'b0, fall_ticks};
  assign past_rise = s1_diff - {16'b0, rise_ticks};

  always_comb begin
    item.seg     = SEG_AFTER;
    item.elapsed = '0;
    item.len     = rise_ticks;
    priority if (s1_before) begin
      item.seg = SEG_BEFORE;
    end else if (s1_diff < {16'b0, rise_ticks}) begin
      item.seg     = SEG_RISE;
      item.elapsed = s1_diff[WIN_W-1:0];
    end else if (s1_diff < {15'b0, total}) begin
      item.seg     = SEG_FALL;
      item.elapsed = past_rise[WIN_W-1:0];
      item.len     = fall_ticks;
    end else begin
      item.seg = SEG_AFTER;
    end
  end

endmodule

### rtl/rfsp_queue.sv
module rfsp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rfsp_pkg::item_t push_item,
  output logic            full,
  output logic            valid,
  output rfsp_pkg::item_t head,
  input  logic            pop
);
  import rfsp_pkg::*;

  logic [1:0] count;
  logic       wptr;
  logic       rptr;
  item_t      mem [2];

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

### rtl/rfsp_cdiv.sv
module rfsp_cdiv #(
  parameter int unsigned N = 32,
  parameter int unsigned D = 6,
  parameter type SIDE_T = logic
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [N-1:0] n,
  input  SIDE_T        in_side,
  output logic         out_valid,
  output logic [N-1:0] quot,
  output SIDE_T        out_side
);
  localparam logic [63:0]   RECIP   = (64'd1 << N) / D;
  localparam int unsigned   MW      = $clog2(RECIP + 64'd1);
  localparam int unsigned   DW      = $clog2(D + 1);
  localparam int unsigned   PW      = N + MW;
  localparam int unsigned   BW      = MW + DW;
  localparam logic [MW-1:0] RECIP_K = RECIP[MW-1:0];
  localparam logic [DW:0]   DIV_K   = (DW+1)'(D);

  logic          v1;
  logic          v2;
  logic [MW-1:0] est1;
  logic [MW-1:0] est2;
  logic [N-1:0]  n1;
  logic [DW:0]   rem2;
  SIDE_T         side1;
  SIDE_T         side2;
  logic [PW-1:0] prod_est;
  logic [BW-1:0] back_prod;
  logic [N-1:0]  rem_full;

  assign prod_est  = PW'(n) * PW'(RECIP_K);
  assign back_prod = BW'(est1) * BW'(DIV_K);
  assign rem_full  = n1 - N'(back_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      est1     <= prod_est[PW-1:N];
      n1       <= n;
      side1    <= in_side;
      est2     <= est1;
      rem2     <= rem_full[DW:0];
      side2    <= side1;
      quot     <= N'(est2) + N'(rem2 >= DIV_K);
      out_side <= side2;
    end
  end

endmodule

### rtl/rfsp_sine.sv
module rfsp_sine #(
  parameter int unsigned PHASE_STEPS = 1024,
  parameter type SIDE_T = logic
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [$clog2(PHASE_STEPS + 1)-1:0]   q,
  input  SIDE_T                                in_side,
  output logic                                 out_valid,
  output logic [15:0]                          sine,
  output SIDE_T                                out_side
);
  localparam int unsigned   QW          = $clog2(PHASE_STEPS + 1);
  localparam logic [63:0]   HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]   COEF_A      = HALF_PI_Q30 / PHASE_STEPS;
  localparam logic [63:0]   COEF_B      = HALF_PI_Q30 % PHASE_STEPS;
  localparam int unsigned   AW          = $clog2(COEF_A + 64'd1);
  localparam int unsigned   BW          = $clog2(PHASE_STEPS);
  localparam int unsigned   PAW         = QW + AW;
  localparam int unsigned   PBW         = QW + BW;
  localparam logic [AW-1:0] A_K         = COEF_A[AW-1:0];
  localparam logic [BW-1:0] B_K         = COEF_B[BW-1:0];
  localparam int unsigned   XW          = 31;
  localparam int unsigned   SW          = 34;

  typedef struct packed {
    logic [PAW-1:0] pa;
    SIDE_T          side;
  } xs_t;

  typedef struct packed {
    logic [31:0]          term;
    logic signed [SW-1:0] sum;
    logic [31:0]          x2;
    SIDE_T                side;
  } chain_t;

  typedef struct packed {
    logic signed [SW-1:0] sum;
    logic [31:0]          x2;
    SIDE_T                side;
  } ts_t;

  logic           av;
  logic [PAW-1:0] pa_a;
  logic [PBW-1:0] pb_a;
  SIDE_T          side_a;
  logic           xv_d;
  logic [PBW-1:0] xq_d;
  xs_t            xs_d;
  logic           xv;
  logic [XW-1:0]  x;
  SIDE_T          side_x;
  logic [61:0]    xx;
  chain_t         c0;
  logic           c0v;

  wire            cv [0:5];
  wire chain_t    cd [0:5];

  logic signed [SW-1:0] fin_sum;
  logic signed [SW-1:0] biased;
  logic [SW-1:0]        rounded;
  logic [15:0]          sine_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      av        <= 1'b0;
      xv        <= 1'b0;
      c0v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      av        <= in_valid;
      xv        <= xv_d;
      c0v       <= xv;
      out_valid <= cv[5];
    end
  end

  rfsp_cdiv #(.N(PBW), .D(PHASE_STEPS), .SIDE_T(xs_t)) u_xdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (av),
    .n         (pb_a),
    .in_side   ('{pa: pa_a, side: side_a}),
    .out_valid (xv_d),
    .quot      (xq_d),
    .out_side  (xs_d)
  );

  assign xx = 62'(x) * 62'(x);

  always_ff @(posedge clk) begin
    if (en) begin
      pa_a    <= PAW'(q) * PAW'(A_K);
      pb_a    <= PBW'(q) * PBW'(B_K);
      side_a  <= in_side;
      x       <= XW'(xs_d.pa) + XW'(xq_d);
      side_x  <= xs_d.side;
      c0.term <= 32'(x);
      c0.sum  <= SW'(x);
      c0.x2   <= 32'(xx >> 30);
      c0.side <= side_x;
      sine    <= sine_next;
      out_side <= cd[5].side;
    end
  end

  assign cv[0] = c0v;
  assign cd[0] = c0;

  for (genvar k = 1; k <= 5; k++) begin : g_term
    localparam int unsigned DK  = (2 * k) * (2 * k + 1);
    localparam bit          ODD = (k % 2) == 1;

    logic        mv;
    logic [31:0] mt;
    ts_t         ms;
    logic [63:0] tprod;
    logic        qv;
    logic [31:0] tq;
    ts_t         qs;

    assign tprod = 64'(cd[k-1].term) * 64'(cd[k-1].x2);

    always_ff @(posedge clk) begin
      if (rst) begin
        mv <= 1'b0;
      end else if (en) begin
        mv <= cv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mt <= 32'(tprod >> 30);
        ms <= '{sum: cd[k-1].sum, x2: cd[k-1].x2, side: cd[k-1].side};
      end
    end

    rfsp_cdiv #(.N(32), .D(DK), .SIDE_T(ts_t)) u_tdiv (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (mv),
      .n         (mt),
      .in_side   (ms),
      .out_valid (qv),
      .quot      (tq),
      .out_side  (qs)
    );

    assign cv[k] = qv;
    assign cd[k] = '{term: tq,
                     sum:  ODD ? qs.sum - SW'(tq) : qs.sum + SW'(tq),
                     x2:   qs.x2,
                     side: qs.side};
  end

  assign fin_sum = cd[5].sum;
  assign biased  = fin_sum + SW'(16384);
  assign rounded = biased >>> 15;

  always_comb begin
    priority if (fin_sum[SW-1]) begin
      sine_next = 16'd0;
    end else if (rounded > SW'(32767)) begin
      sine_next = 16'd32767;
    end else begin
      sine_next = rounded[15:0];
    end
  end

endmodule

### rtl/rfsp_back.sv
module rfsp_back #(
  parameter int unsigned PHASE_STEPS = 1024,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  rfsp_pkg::item_t item,
  output logic            item_pop,
  input  logic [15:0]     peak_level,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output logic [15:0]     profile_value,
  output logic [1:0]      segment
);
  import rfsp_pkg::*;

  localparam int unsigned PB = $clog2(PHASE_STEPS);
  localparam int unsigned QW = $clog2(PHASE_STEPS + 1);
  localparam int unsigned NW = WIN_W + QW;
  localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (VALUE_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

  typedef struct packed {
    logic [WIN_W-1:0] rem;
    logic [PB-1:0]    rest;
    logic [PB-1:0]    quot;
    logic [WIN_W-1:0] len;
    seg_t             seg;
  } dstage_t;

  function automatic dstage_t div_step(dstage_t cur);
    dstage_t        nxt;
    logic [WIN_W:0] trial;
    logic           ge;
    trial    = {cur.rem, cur.rest[PB-1]};
    ge       = trial >= {1'b0, cur.len};
    nxt      = cur;
    nxt.rem  = ge ? WIN_W'(trial - {1'b0, cur.len}) : trial[WIN_W-1:0];
    nxt.rest = {cur.rest[PB-2:0], 1'b0};
    nxt.quot = {cur.quot[PB-2:0], ge};
    return nxt;
  endfunction

  logic              adv;
  logic              mv;
  logic [NW-1:0]     m_n;
  logic [WIN_W-1:0]  m_len;
  seg_t              m_seg;
  dstage_t           d0;
  dstage_t           dregs [1:PB];
  logic              dvr [1:PB];
  logic [QW-1:0]     phase_q;
  logic              sv;
  logic [15:0]       sine;
  seg_t              s_seg;
  logic              pv;
  logic signed [32:0] prod;
  seg_t              p_seg;
  logic signed [15:0] peak_s;
  logic signed [16:0] sine_s;
  logic signed [32:0] biased;
  logic signed [17:0] val;
  logic signed [VALUE_BITS-1:0] sat_val;
  logic [15:0]       value_next;

  assign adv      = !rsp_valid || rsp_ready;
  assign item_pop = adv && item_valid;

  assign d0 = '{rem: WIN_W'(m_n >> PB), rest: m_n[PB-1:0], quot: '0, len: m_len, seg: m_seg};

  assign phase_q = (dregs[PB].seg == SEG_RISE) ? QW'(dregs[PB].quot)
                                                : QW'(PHASE_STEPS) - QW'(dregs[PB].quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      mv        <= 1'b0;
      dvr       <= '{default: 1'b0};
      pv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      mv     <= item_valid;
      dvr[1] <= mv;
      for (int i = 1; i < PB; i++) begin
        dvr[i+1] <= dvr[i];
      end
      pv        <= sv;
      rsp_valid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_n      <= NW'(item.elapsed) * NW'(PHASE_STEPS);
      m_len    <= item.len;
      m_seg    <= item.seg;
      dregs[1] <= div_step(d0);
      for (int i = 1; i < PB; i++) begin
        dregs[i+1] <= div_step(dregs[i]);
      end
      prod          <= peak_s * sine_s;
      p_seg         <= s_seg;
      profile_value <= value_next;
      segment       <= p_seg;
    end
  end

  rfsp_sine #(.PHASE_STEPS(PHASE_STEPS), .SIDE_T(seg_t)) u_sine (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (dvr[PB]),
    .q         (phase_q),
    .in_side   (dregs[PB].seg),
    .out_valid (sv),
    .sine      (sine),
    .out_side  (s_seg)
  );

  assign peak_s = peak_level;
  assign sine_s = {1'b0, sine};
  assign biased = prod + 33'sd16384;
  assign val    = 18'(biased >>> 15);

  always_comb begin
    priority if (val > SAT_HI) begin
      sat_val = VALUE_BITS'(SAT_HI);
    end else if (val < SAT_LO) begin
      sat_val = VALUE_BITS'(SAT_LO);
    end else begin
      sat_val = VALUE_BITS'(val);
    end
    value_next = (p_seg == SEG_RISE || p_seg == SEG_FALL) ? 16'(sat_val) : 16'd0;
  end

endmodule

### rtl/rise_fall_sine_profile.sv
// Rise/fall sine assist profile.
// Request channel (req_valid/req_ready, time_now): one time stamp per request.
// Response channel (rsp_valid/rsp_ready): profile_value and segment, one per
// request, in request order. Before start_tick the value is 0 (segment 0); for
// rise_ticks ticks it follows peak_level * sin (segment 1), then for fall_ticks
// ticks peak_level * cos (segment 2), then 0 (segment 3).
// Configuration goes over the APB port: start_tick at 0x0, rise_ticks at 0x4,
// fall_ticks at 0x8, peak_level at 0xC; write only while no request is in flight.
// Throughput: one request per cycle while the receiver does not stall. A request
// passes the classifier register, the queue, the phase multiplier register, the
// one-bit-per-stage phase divider, the sine series pipeline with its constant
// dividers, the product register and the output register before rsp_valid.
// Reset clears the pipeline and restores the register defaults. When the
// receiver stalls, the back pipeline holds in place and the two-entry queue
// behind the classifier absorbs requests until it fills, then req_ready drops.
module rise_fall_sine_profile #(
  parameter int unsigned PHASE_STEPS = 1024,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [31:0] time_now,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [15:0] profile_value,
  output logic [1:0]  segment,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rfsp_pkg::*;

  logic [31:0] start_tick;
  logic [15:0] rise_ticks;
  logic [15:0] fall_ticks;
  logic [15:0] peak_level;
  logic        wr;
  reg_idx_t    idx;
  logic        push;
  item_t       push_item;
  logic        full;
  logic        q_valid;
  item_t       q_head;
  logic        q_pop;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_tick <= 32'd0;
      rise_ticks <= 16'd1;
      fall_ticks <= 16'd1;
      peak_level <= 16'd0;
    end else if (wr) begin
      unique case (idx)
        REG_START: start_tick <= pwdata;
        REG_RISE:  rise_ticks <= pwdata[15:0];
        REG_FALL:  fall_ticks <= pwdata[15:0];
        REG_PEAK:  peak_level <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START: prdata = start_tick;
      REG_RISE:  prdata = {16'd0, rise_ticks};
      REG_FALL:  prdata = {16'd0, fall_ticks};
      REG_PEAK:  prdata = {16'd0, peak_level};
    endcase
  end

  rfsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .time_now   (time_now),
    .start_tick (start_tick),
    .rise_ticks (rise_ticks),
    .fall_ticks (fall_ticks),
    .push       (push),
    .item       (push_item),
    .full       (full)
  );

  rfsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  rfsp_back #(.PHASE_STEPS(PHASE_STEPS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (q_valid),
    .item          (q_head),
    .item_pop      (q_pop),
    .peak_level    (peak_level),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .profile_value (profile_value),
    .segment       (segment)
  );

endmodule

### rtl/rfsp_checker.sv
module rfsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] profile_value,
  input logic [1:0]  segment,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  import rfsp_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(profile_value) && $stable(segment))
    else $error("response changed while stalled");

  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (segment == SEG_BEFORE || segment == SEG_AFTER) |-> profile_value == 16'd0)
    else $error("nonzero value outside the rise and fall windows");

  a_rise_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[3:2] == REG_RISE
    |=> paddr[3:2] != REG_RISE || prdata == {16'd0, $past(pwdata[15:0])})
    else $error("rise_ticks readback mismatch");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("pipeline not idle after reset");

endmodule

bind rise_fall_sine_profile rfsp_checker u_rfsp_checker (.*);
